>>> hw/rtl/aes_rf_pkg.sv
// Shared types, constant tables and GF(2^8) helpers for the AES round core.
package aes_rf_pkg;

    // 16-byte block, byte 0 at the most significant position
    typedef logic [0:15][7:0] blk_t;
    // one column, row 0 first
    typedef logic [0:3][7:0] col_t;

    // request type codes; bit 1 selects the inverse path
    typedef enum logic [1:0] {
        REQ_FULL  = 2'd0,
        REQ_FINAL = 2'd1,
        REQ_INV   = 2'd2,
        REQ_INV_B = 2'd3
    } req_type_t;

    // control carried to each column lane
    typedef struct packed {
        logic inv;
        logic mix;
    } lane_ctrl_t;

    // control carried to the merge stage
    typedef struct packed {
        logic valid;
        logic inv;
    } merge_ctrl_t;

    localparam logic [7:0] GF_POLY = 8'h1b;

    localparam logic [3:0] FWD_COEF [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
    localparam logic [3:0] INV_COEF [4] = '{4'he, 4'hb, 4'hd, 4'h9};

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // multiply by x with reduction
    function automatic logic [7:0] gf_x2(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
    endfunction

    // product with a constant of at most four bits, shift-and-add
    function automatic logic [7:0] gf_mul(input logic [7:0] v, input logic [3:0] c);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p   = v;
        for (int i = 0; i < 4; i++)
        begin
            if (c[i])
            begin
                acc = acc ^ p;
            end
            p = gf_x2(p);
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/aes_rf_lane.sv
// One column lane: forward or inverse MixColumns, or a pass-through, on a single column, registered.
module aes_rf_lane (
    input  logic                   clk,
    input  aes_rf_pkg::lane_ctrl_t ctrl,
    input  aes_rf_pkg::col_t       col_in,
    output aes_rf_pkg::col_t       col_out
);
    import aes_rf_pkg::*;

    col_t col_next;
    col_t col_reg;

    // matrix product over the column; final rounds pass the column through
    always_comb
    begin
        logic [1:0] idx;
        logic [7:0] acc;
        col_next = col_in;
        for (int r = 0; r < 4; r++)
        begin
            acc = 8'h00;
            for (int j = 0; j < 4; j++)
            begin
                idx = 2'(4 + j - r);
                if (ctrl.inv)
                begin
                    acc = acc ^ gf_mul(col_in[j], INV_COEF[idx]);
                end
                else
                begin
                    acc = acc ^ gf_mul(col_in[j], FWD_COEF[idx]);
                end
            end
            if (ctrl.inv || ctrl.mix)
            begin
                col_next[r] = acc;
            end
        end
    end

    // lane output register
    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
    end

    assign col_out = col_reg;

endmodule

>>> hw/rtl/aes_rf_merge.sv
// Merge stage: gathers the lane columns and finishes the round, registered result.
module aes_rf_merge (
    input  logic                    clk,
    input  logic                    rst_n,
    input  aes_rf_pkg::merge_ctrl_t ctrl,
    input  aes_rf_pkg::blk_t        mixed,
    input  aes_rf_pkg::blk_t        rkey,
    output logic                    done,
    output logic [63:0]             result_hi,
    output logic [63:0]             result_lo
);
    import aes_rf_pkg::*;

    blk_t res_next;
    blk_t res_reg;
    logic done_reg;

    // inverse: InvShiftRows then InvSubBytes; forward: AddRoundKey
    always_comb
    begin
        logic [1:0] src;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                src = 2'(c + 3 * r);
                if (ctrl.inv)
                begin
                    res_next[4 * r + c] = INV_SBOX[mixed[4 * r + 32'(src)]];
                end
                else
                begin
                    res_next[4 * r + c] = mixed[4 * r + c] ^ rkey[4 * r + c];
                end
            end
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done      = done_reg;
    assign result_hi = res_reg[0:7];
    assign result_lo = res_reg[8:15];

endmodule

>>> hw/rtl/aes_round_function_core.sv
// Top level of the AES round core: input stage, four column lanes and merge stage.
// One AES round per item (full encrypt, final encrypt, or inverse). An item is taken
// at any edge with start high; busy is always low, so an item can enter every cycle.
// Each result appears on result_hi/result_lo for one cycle with done high, in order,
// after three register stages: input stage (S-box or key add), column lanes
// (MixColumns), merge stage (key add or inverse S-box). The result is shown once and
// must be captured in that cycle.
module aes_round_function_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [63:0] state_hi,
    input  logic [63:0] state_lo,
    input  logic [63:0] key_hi,
    input  logic [63:0] key_lo,
    output logic        done,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);
    import aes_rf_pkg::*;

    blk_t       in_state;
    blk_t       in_key;
    blk_t       s1_next;
    blk_t       s1_state_reg;
    blk_t       s1_key_reg;
    blk_t       s2_key_reg;
    blk_t       shifted;
    blk_t       mixed;
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       s1_inv_reg;
    logic       s1_mix_reg;
    logic       s2_inv_reg;
    logic       accept;
    lane_ctrl_t lane_ctrl;
    merge_ctrl_t merge_ctrl;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign in_state = {state_hi, state_lo};
    assign in_key   = {key_hi, key_lo};

    // input stage: inverse adds the key first, forward does SubBytes
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            if (req_type[1])
            begin
                s1_next[k] = in_state[k] ^ in_key[k];
            end
            else
            begin
                s1_next[k] = FWD_SBOX[in_state[k]];
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload and mode
    always_ff @(posedge clk)
    begin
        s1_state_reg <= s1_next;
        s1_key_reg   <= in_key;
        s1_inv_reg   <= req_type[1];
        s1_mix_reg   <= (req_type_t'(req_type) == REQ_FULL);
        s2_key_reg   <= s1_key_reg;
        s2_inv_reg   <= s1_inv_reg;
    end

    // forward ShiftRows ahead of the lanes
    always_comb
    begin
        logic [1:0] src;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                src = 2'(c + r);
                if (s1_inv_reg)
                begin
                    shifted[4 * r + c] = s1_state_reg[4 * r + c];
                end
                else
                begin
                    shifted[4 * r + c] = s1_state_reg[4 * r + 32'(src)];
                end
            end
        end
    end

    assign lane_ctrl.inv = s1_inv_reg;
    assign lane_ctrl.mix = s1_mix_reg;

    // four column lanes
    for (genvar c = 0; c < 4; c++)
    begin : g_lane
        col_t col_in;
        col_t col_out;

        assign col_in = {shifted[c], shifted[4 + c], shifted[8 + c], shifted[12 + c]};

        aes_rf_lane u_lane (
            .clk     (clk),
            .ctrl    (lane_ctrl),
            .col_in  (col_in),
            .col_out (col_out)
        );

        assign mixed[c]      = col_out[0];
        assign mixed[4 + c]  = col_out[1];
        assign mixed[8 + c]  = col_out[2];
        assign mixed[12 + c] = col_out[3];
    end

    assign merge_ctrl.valid = s2_valid_reg;
    assign merge_ctrl.inv   = s2_inv_reg;

    aes_rf_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .mixed     (mixed),
        .rkey      (s2_key_reg),
        .done      (done),
        .result_hi (result_hi),
        .result_lo (result_lo)
    );

endmodule
